FILE: sv/vsa_pkg.sv
// Shared types, constants and arithmetic helpers for the video scope accumulator.
package vsa_pkg;

  localparam int WAVE_WIDTH  = 256;
  localparam int WAVE_HEIGHT = 256;
  localparam int VECTOR_SIZE = 256;

  localparam int PLANE_BINS = WAVE_WIDTH * WAVE_HEIGHT;
  localparam int VEC_BINS   = VECTOR_SIZE * VECTOR_SIZE;
  localparam int HIST_BINS  = 256;
  localparam int HIST_COUNT = 4;
  localparam int PLANES     = 3;

  localparam int PLANE_AW = $clog2(PLANE_BINS);
  localparam int VEC_AW   = $clog2(VEC_BINS);
  localparam int HIST_AW  = $clog2(HIST_BINS);

  localparam int SXW  = $clog2(WAVE_WIDTH);
  localparam int ROWW = $clog2(WAVE_HEIGHT);
  localparam int VSW  = $clog2(VECTOR_SIZE);

  localparam int MAXD0 = (PLANE_BINS > VEC_BINS) ? PLANE_BINS : VEC_BINS;
  localparam int MAXD  = (MAXD0 > HIST_BINS) ? MAXD0 : HIST_BINS;
  localparam int CLRW  = $clog2(MAXD);

  // column scaling: num = cx * (WAVE_WIDTH-1), den = effective width - 1
  localparam int CXW  = 12;
  localparam int FWW  = 13;
  localparam int NUMW = CXW + SXW;
  localparam int FW_MAX = 4096;

  // divide-by-255 through a reciprocal plus one correction step
  localparam int SCALE_MAX = (VECTOR_SIZE > WAVE_HEIGHT) ? VECTOR_SIZE : WAVE_HEIGHT;
  localparam int DIVW      = $clog2(255 * SCALE_MAX);
  localparam int RK        = DIVW + 8;
  localparam longint RECIP255 = (64'd1 << RK) / 64'd255;
  localparam int PEW       = 2 * DIVW + 8;

  // fixed-point luma and chroma
  localparam int W_R  = 13933;
  localparam int W_G  = 46871;
  localparam int W_B  = 4732;
  localparam int K_CB = 35318;
  localparam int K_CR = 41615;
  localparam int CHW  = 45;
  localparam int NW   = 40;
  localparam int NPW  = NW + VSW + 1;
  localparam longint CHROMA_DEN  = 64'd255 << 32;
  localparam longint CHROMA_HALF = 64'd255 << 31;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [3:0] SEL_HIST_R   = 4'd0;
  localparam logic [3:0] SEL_HIST_G   = 4'd1;
  localparam logic [3:0] SEL_HIST_B   = 4'd2;
  localparam logic [3:0] SEL_HIST_Y   = 4'd3;
  localparam logic [3:0] SEL_WAVE     = 4'd4;
  localparam logic [3:0] SEL_PARADE_R = 4'd5;
  localparam logic [3:0] SEL_PARADE_G = 4'd6;
  localparam logic [3:0] SEL_PARADE_B = 4'd7;
  localparam logic [3:0] SEL_VECTOR   = 4'd8;
  localparam logic [3:0] SEL_COUNT    = 4'd9;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_SWAP        = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [3:0]  store_select;
    logic [15:0] bin_index;
    logic        clear_after;
  } vsa_in_t;

  typedef struct packed {
    logic [3:0]  read_store;
    logic [15:0] read_index;
    logic [31:0] count;
  } vsa_out_t;

  // rows: 0 red, 1 green, 2 blue, 3 luma
  typedef struct packed {
    logic [7:0]                luma;
    logic [3:0][ROWW-1:0]      row;
    logic [VSW-1:0]            vx;
    logic [VSW-1:0]            vy;
  } vsa_geom_t;

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [DIVW-1:0] div255_est(input logic [DIVW-1:0] t);
    logic [PEW-1:0] p;
    p = PEW'(t) * PEW'(RECIP255);
    return p[RK +: DIVW];
  endfunction

  function automatic logic [DIVW-1:0] div255_fix(input logic [DIVW-1:0] t,
                                                 input logic [DIVW-1:0] q0);
    logic [DIVW+8:0] qm;
    logic [DIVW+8:0] rr;
    qm = {1'b0, q0, 8'd0} - (DIVW+9)'(q0);
    rr = (DIVW+9)'(t) - qm;
    return (rr >= (DIVW+9)'(255)) ? q0 + DIVW'(1) : q0;
  endfunction

endpackage

FILE: sv/vsa_ram.sv
// Single-port synchronous RAM with a registered read.
module vsa_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: sv/vsa_div.sv
// Bit-serial restoring divider for the waveform column scaling.
module vsa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [vsa_pkg::NUMW-1:0]    num,
  input  logic [vsa_pkg::CXW-1:0]     den,
  output logic                        busy,
  output logic [vsa_pkg::NUMW-1:0]    quo
);

  localparam int CW = $clog2(vsa_pkg::NUMW + 1);

  logic [vsa_pkg::CXW-1:0] rem;
  logic [vsa_pkg::CXW-1:0] dvs;
  logic [CW-1:0]           cnt;
  logic [vsa_pkg::CXW:0]   rem_sh;
  logic                    fits;

  assign rem_sh = {rem, quo[vsa_pkg::NUMW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(vsa_pkg::NUMW);
    end else if (busy) begin
      cnt  <= cnt - CW'(1);
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= vsa_pkg::CXW'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[vsa_pkg::CXW-1:0];
      end
      quo <= {quo[vsa_pkg::NUMW-2:0], fits};
    end
  end

endmodule

FILE: sv/vsa_math.sv
// Luma, waveform rows and vectorscope position pipeline (six stages).
module vsa_math (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               busy,
  output vsa_pkg::vsa_geom_t geom
);

  localparam int DW = vsa_pkg::DIVW;

  logic [5:0] vld;

  logic [23:0] pr1, pg1, pb1;
  logic [7:0]  r1, g1, b1;

  logic [23:0] yq2;
  logic [7:0]  y2, r2, g2, b2;
  logic [24:0] ysum;

  logic signed [25:0] db, dr;
  logic signed [vsa_pkg::CHW-1:0] cb3, cr3;
  logic [3:0][DW-1:0] rp3;
  logic [7:0] y3;

  logic [vsa_pkg::NW-1:0] ncb, ncr;
  logic [vsa_pkg::NPW-1:0] mcb, mcr;
  logic [DW-1:0] tcb4, tcr4;
  logic [3:0][DW-1:0] rp4, rq4;
  logic [7:0] y4;

  logic [DW-1:0] tcb5, tcr5, qcb5, qcr5;
  logic [3:0][vsa_pkg::ROWW-1:0] row5;
  logic [7:0] y5;

  logic [DW-1:0] qcb6, qcr6;

  function automatic logic [vsa_pkg::NW-1:0] clamp_n(input logic signed [vsa_pkg::CHW-1:0] v);
    if (v[vsa_pkg::CHW-1]) begin
      return '0;
    end else if (v > vsa_pkg::CHW'(vsa_pkg::CHROMA_DEN)) begin
      return vsa_pkg::NW'(vsa_pkg::CHROMA_DEN);
    end else begin
      return v[vsa_pkg::NW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
  end

  assign busy = |vld;

  // stage 1: luma weight products
  always_ff @(posedge clk) begin
    if (start) begin
      pr1 <= 24'(vsa_pkg::W_R) * 24'(red);
      pg1 <= 24'(vsa_pkg::W_G) * 24'(green);
      pb1 <= 24'(vsa_pkg::W_B) * 24'(blue);
      r1  <= red;
      g1  <= green;
      b1  <= blue;
    end
  end

  // stage 2: luma sum and rounding
  assign ysum = 25'(pr1 + pg1 + pb1) + 25'd32768;

  always_ff @(posedge clk) begin
    yq2 <= pr1 + pg1 + pb1;
    y2  <= (ysum[24:16] > 9'd255) ? 8'd255 : ysum[23:16];
    r2  <= r1;
    g2  <= g1;
    b2  <= b1;
  end

  // stage 3: chroma numerators, row products
  assign db = $signed({2'b0, b2, 16'd0}) - $signed({2'b0, yq2});
  assign dr = $signed({2'b0, r2, 16'd0}) - $signed({2'b0, yq2});

  always_ff @(posedge clk) begin
    cb3 <= vsa_pkg::CHW'(db) * vsa_pkg::CHW'(vsa_pkg::K_CB)
           + vsa_pkg::CHW'(vsa_pkg::CHROMA_HALF);
    cr3 <= vsa_pkg::CHW'(dr) * vsa_pkg::CHW'(vsa_pkg::K_CR)
           + vsa_pkg::CHW'(vsa_pkg::CHROMA_HALF);
    rp3[0] <= DW'(r2) * DW'(vsa_pkg::WAVE_HEIGHT - 1);
    rp3[1] <= DW'(g2) * DW'(vsa_pkg::WAVE_HEIGHT - 1);
    rp3[2] <= DW'(b2) * DW'(vsa_pkg::WAVE_HEIGHT - 1);
    rp3[3] <= DW'(y2) * DW'(vsa_pkg::WAVE_HEIGHT - 1);
    y3 <= y2;
  end

  // stage 4: clamp and scale chroma, estimate row quotients
  assign ncb = clamp_n(cb3);
  assign ncr = clamp_n(cr3);
  assign mcb = vsa_pkg::NPW'(ncb) * vsa_pkg::NPW'(vsa_pkg::VECTOR_SIZE - 1)
               + vsa_pkg::NPW'(vsa_pkg::CHROMA_HALF);
  assign mcr = vsa_pkg::NPW'(ncr) * vsa_pkg::NPW'(vsa_pkg::VECTOR_SIZE - 1)
               + vsa_pkg::NPW'(vsa_pkg::CHROMA_HALF);

  always_ff @(posedge clk) begin
    tcb4 <= mcb[32 +: DW];
    tcr4 <= mcr[32 +: DW];
    for (int i = 0; i < 4; i++) begin
      rp4[i] <= rp3[i];
      rq4[i] <= vsa_pkg::div255_est(rp3[i]);
    end
    y4 <= y3;
  end

  // stage 5: finish rows, estimate chroma quotients
  always_ff @(posedge clk) begin
    tcb5 <= tcb4;
    tcr5 <= tcr4;
    qcb5 <= vsa_pkg::div255_est(tcb4);
    qcr5 <= vsa_pkg::div255_est(tcr4);
    for (int i = 0; i < 4; i++) begin
      row5[i] <= vsa_pkg::ROWW'(vsa_pkg::WAVE_HEIGHT - 1)
                 - vsa_pkg::ROWW'(vsa_pkg::div255_fix(rp4[i], rq4[i]));
    end
    y5 <= y4;
  end

  // stage 6: finish chroma
  assign qcb6 = vsa_pkg::div255_fix(tcb5, qcb5);
  assign qcr6 = vsa_pkg::div255_fix(tcr5, qcr5);

  always_ff @(posedge clk) begin
    geom.luma <= y5;
    geom.row  <= row5;
    geom.vx   <= vsa_pkg::VSW'(qcb6);
    geom.vy   <= vsa_pkg::VSW'(vsa_pkg::VECTOR_SIZE - 1) - vsa_pkg::VSW'(qcr6);
  end

endmodule

FILE: sv/video_scope_accumulator.sv
// Top level of the video scope accumulator: sequencer, scope memories and result register.
// An accumulate beat is paced by the bit-serial divider that maps the source column onto a
// waveform column; the six-stage luma/chroma pipeline runs alongside it, then every store
// is read (S_RD) and written back (S_WR), all memories in parallel. A read beat reads the
// bin (S_RDBIN), then waits in S_RESP until the result register is free. After reset a
// clearing pass zeroes the memories one address per cycle, during which item_stall stays
// high; configuration writes belong in gaps where no beat is in flight.
module video_scope_accumulator (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  vsa_pkg::vsa_in_t item,
  output logic             result_valid,
  input  logic             result_stall,
  output vsa_pkg::vsa_out_t result,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [12:0]      cfg_data
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MATH  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_WR    = 7'b0010000,
    S_RDBIN = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [vsa_pkg::FWW-1:0]  frame_width;
  logic                     swap_red_blue;
  logic [vsa_pkg::CLRW-1:0] clr_cnt;
  logic [31:0]              pixel_count;
  vsa_pkg::vsa_in_t         in_q;

  logic accept, acc_start, out_free, resp_go;

  logic [7:0] raw_r, raw_b, rr, bb;
  logic [vsa_pkg::FWW-1:0] fw_eff;
  logic [vsa_pkg::CXW-1:0] fwm1, den, cx;
  logic [vsa_pkg::NUMW-1:0] num, quo;
  logic div_busy, math_busy;
  vsa_pkg::vsa_geom_t geom;
  logic [vsa_pkg::SXW-1:0] sx;

  logic [3:0]                              hist_en, hist_we, hist_hit;
  logic [3:0][vsa_pkg::HIST_AW-1:0]        hist_addr;
  logic [3:0][31:0]                        hist_wdata, hist_rdata;
  logic                                    wave_en, wave_we, wave_hit;
  logic [vsa_pkg::PLANE_AW-1:0]            wave_addr;
  logic [15:0]                             wave_wdata, wave_rdata;
  logic [2:0]                              par_en, par_we, par_hit;
  logic [2:0][vsa_pkg::PLANE_AW-1:0]       par_addr;
  logic [2:0][15:0]                        par_wdata, par_rdata;
  logic                                    vec_en, vec_we, vec_hit;
  logic [vsa_pkg::VEC_AW-1:0]              vec_addr;
  logic [15:0]                             vec_wdata, vec_rdata;
  logic                                    cnt_hit;

  logic [vsa_pkg::PLANE_AW-1:0] acc_wave_addr;
  logic [2:0][vsa_pkg::PLANE_AW-1:0] acc_par_addr;
  logic [vsa_pkg::VEC_AW-1:0] acc_vec_addr;
  logic [31:0] resp_count;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign acc_start  = accept && (item.operation == vsa_pkg::OP_ACCUM);
  assign out_free   = !result_valid || !result_stall;
  assign resp_go    = (state == S_RESP) && out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= vsa_pkg::FWW'(1);
      swap_red_blue <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vsa_pkg::REG_FRAME_WIDTH: frame_width   <= cfg_data;
        vsa_pkg::REG_SWAP:        swap_red_blue <= cfg_data[0];
      endcase
    end
  end

  // column scaling setup
  assign raw_r  = swap_red_blue ? item.blue : item.red;
  assign raw_b  = swap_red_blue ? item.red : item.blue;
  assign fw_eff = (frame_width == '0) ? vsa_pkg::FWW'(1) :
                  (frame_width > vsa_pkg::FWW'(vsa_pkg::FW_MAX)) ?
                  vsa_pkg::FWW'(vsa_pkg::FW_MAX) : frame_width;
  assign fwm1   = vsa_pkg::CXW'(fw_eff - vsa_pkg::FWW'(1));
  assign den    = (fw_eff > vsa_pkg::FWW'(1)) ? fwm1 : vsa_pkg::CXW'(1);
  assign cx     = (item.column < fwm1) ? item.column : fwm1;
  assign num    = vsa_pkg::NUMW'(cx) * vsa_pkg::NUMW'(vsa_pkg::WAVE_WIDTH - 1);
  assign sx     = quo[vsa_pkg::SXW-1:0];

  vsa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (acc_start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .quo   (quo)
  );

  vsa_math u_math (
    .clk   (clk),
    .rst   (rst),
    .start (acc_start),
    .red   (raw_r),
    .green (item.green),
    .blue  (raw_b),
    .busy  (math_busy),
    .geom  (geom)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == vsa_pkg::CLRW'(vsa_pkg::MAXD - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_next = (item.operation == vsa_pkg::OP_ACCUM) ? S_MATH : S_RDBIN;
        end
      end
      S_MATH:  if (!math_busy && !div_busy) state_next = S_RD;
      S_RD:    state_next = S_WR;
      S_WR:    state_next = S_IDLE;
      S_RDBIN: state_next = S_RESP;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + vsa_pkg::CLRW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= item;
    end
  end

  // read-select decode
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hist_hit[i] = (in_q.store_select == 4'(i)) &&
                    (32'(in_q.bin_index) < 32'(vsa_pkg::HIST_BINS));
    end
    wave_hit = (in_q.store_select == vsa_pkg::SEL_WAVE) &&
               (32'(in_q.bin_index) < 32'(vsa_pkg::PLANE_BINS));
    par_hit[0] = (in_q.store_select == vsa_pkg::SEL_PARADE_R) &&
                 (32'(in_q.bin_index) < 32'(vsa_pkg::PLANE_BINS));
    par_hit[1] = (in_q.store_select == vsa_pkg::SEL_PARADE_G) &&
                 (32'(in_q.bin_index) < 32'(vsa_pkg::PLANE_BINS));
    par_hit[2] = (in_q.store_select == vsa_pkg::SEL_PARADE_B) &&
                 (32'(in_q.bin_index) < 32'(vsa_pkg::PLANE_BINS));
    vec_hit = (in_q.store_select == vsa_pkg::SEL_VECTOR) &&
              (32'(in_q.bin_index) < 32'(vsa_pkg::VEC_BINS));
    cnt_hit = (in_q.store_select == vsa_pkg::SEL_COUNT) && (in_q.bin_index == '0);
  end

  // accumulate addresses
  assign rr = swap_red_blue ? in_q.blue : in_q.red;
  assign bb = swap_red_blue ? in_q.red : in_q.blue;
  assign acc_wave_addr = vsa_pkg::PLANE_AW'(geom.row[3]) * vsa_pkg::PLANE_AW'(vsa_pkg::WAVE_WIDTH)
                         + vsa_pkg::PLANE_AW'(sx);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_par_addr[i] = vsa_pkg::PLANE_AW'(geom.row[i])
                        * vsa_pkg::PLANE_AW'(vsa_pkg::WAVE_WIDTH) + vsa_pkg::PLANE_AW'(sx);
    end
  end
  assign acc_vec_addr = vsa_pkg::VEC_AW'(geom.vy) * vsa_pkg::VEC_AW'(vsa_pkg::VECTOR_SIZE)
                        + vsa_pkg::VEC_AW'(geom.vx);

  // memory port control
  always_comb begin
    hist_en = '0; hist_we = '0; hist_addr = '0; hist_wdata = '0;
    wave_en = 1'b0; wave_we = 1'b0; wave_addr = '0; wave_wdata = '0;
    par_en = '0; par_we = '0; par_addr = '0; par_wdata = '0;
    vec_en = 1'b0; vec_we = 1'b0; vec_addr = '0; vec_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        for (int i = 0; i < 4; i++) begin
          hist_en[i]   = 32'(clr_cnt) < 32'(vsa_pkg::HIST_BINS);
          hist_addr[i] = clr_cnt[vsa_pkg::HIST_AW-1:0];
        end
        hist_we = hist_en;
        wave_en   = 32'(clr_cnt) < 32'(vsa_pkg::PLANE_BINS);
        wave_we   = wave_en;
        wave_addr = vsa_pkg::PLANE_AW'(clr_cnt);
        for (int i = 0; i < 3; i++) begin
          par_en[i]   = wave_en;
          par_addr[i] = vsa_pkg::PLANE_AW'(clr_cnt);
        end
        par_we = par_en;
        vec_en   = 32'(clr_cnt) < 32'(vsa_pkg::VEC_BINS);
        vec_we   = vec_en;
        vec_addr = vsa_pkg::VEC_AW'(clr_cnt);
      end
      S_RD, S_WR: begin
        hist_en   = '1;
        hist_addr = {geom.luma, bb, in_q.green, rr};
        wave_en   = 1'b1;
        wave_addr = acc_wave_addr;
        par_en    = '1;
        par_addr  = acc_par_addr;
        vec_en    = 1'b1;
        vec_addr  = acc_vec_addr;
        if (state == S_WR) begin
          hist_we = '1;
          wave_we = 1'b1;
          par_we  = '1;
          vec_we  = 1'b1;
          for (int i = 0; i < 4; i++) hist_wdata[i] = vsa_pkg::bump32(hist_rdata[i]);
          for (int i = 0; i < 3; i++) par_wdata[i] = vsa_pkg::bump16(par_rdata[i]);
          wave_wdata = vsa_pkg::bump16(wave_rdata);
          vec_wdata  = vsa_pkg::bump16(vec_rdata);
        end
      end
      S_RDBIN, S_RESP: begin
        for (int i = 0; i < 4; i++) hist_addr[i] = in_q.bin_index[vsa_pkg::HIST_AW-1:0];
        wave_addr = vsa_pkg::PLANE_AW'(in_q.bin_index);
        for (int i = 0; i < 3; i++) par_addr[i] = vsa_pkg::PLANE_AW'(in_q.bin_index);
        vec_addr = vsa_pkg::VEC_AW'(in_q.bin_index);
        if (state == S_RDBIN) begin
          hist_en = hist_hit;
          wave_en = wave_hit;
          par_en  = par_hit;
          vec_en  = vec_hit;
        end else if (resp_go && in_q.clear_after) begin
          hist_en = hist_hit;
          hist_we = hist_hit;
          wave_en = wave_hit;
          wave_we = wave_hit;
          par_en  = par_hit;
          par_we  = par_hit;
          vec_en  = vec_hit;
          vec_we  = vec_hit;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < vsa_pkg::HIST_COUNT; i++) begin : g_hist
    vsa_ram #(.DEPTH(vsa_pkg::HIST_BINS), .WIDTH(32)) u_ram (
      .clk   (clk),
      .en    (hist_en[i]),
      .we    (hist_we[i]),
      .addr  (hist_addr[i]),
      .wdata (hist_wdata[i]),
      .rdata (hist_rdata[i])
    );
  end

  vsa_ram #(.DEPTH(vsa_pkg::PLANE_BINS), .WIDTH(16)) u_wave (
    .clk   (clk),
    .en    (wave_en),
    .we    (wave_we),
    .addr  (wave_addr),
    .wdata (wave_wdata),
    .rdata (wave_rdata)
  );

  for (genvar i = 0; i < vsa_pkg::PLANES; i++) begin : g_parade
    vsa_ram #(.DEPTH(vsa_pkg::PLANE_BINS), .WIDTH(16)) u_ram (
      .clk   (clk),
      .en    (par_en[i]),
      .we    (par_we[i]),
      .addr  (par_addr[i]),
      .wdata (par_wdata[i]),
      .rdata (par_rdata[i])
    );
  end

  vsa_ram #(.DEPTH(vsa_pkg::VEC_BINS), .WIDTH(16)) u_vec (
    .clk   (clk),
    .en    (vec_en),
    .we    (vec_we),
    .addr  (vec_addr),
    .wdata (vec_wdata),
    .rdata (vec_rdata)
  );

  // pixel count
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
    end else if (state == S_WR) begin
      pixel_count <= vsa_pkg::bump32(pixel_count);
    end else if (resp_go && cnt_hit && in_q.clear_after) begin
      pixel_count <= '0;
    end
  end

  // result select
  always_comb begin
    resp_count = '0;
    priority if (|hist_hit) begin
      resp_count = hist_rdata[in_q.store_select[1:0]];
    end else if (wave_hit) begin
      resp_count = 32'(wave_rdata);
    end else if (par_hit[0]) begin
      resp_count = 32'(par_rdata[0]);
    end else if (par_hit[1]) begin
      resp_count = 32'(par_rdata[1]);
    end else if (par_hit[2]) begin
      resp_count = 32'(par_rdata[2]);
    end else if (vec_hit) begin
      resp_count = 32'(vec_rdata);
    end else if (cnt_hit) begin
      resp_count = pixel_count;
    end else begin
      resp_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (resp_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_go) begin
      result.read_store <= in_q.store_select;
      result.read_index <= in_q.bin_index;
      result.count      <= resp_count;
    end
  end

endmodule

FILE: sv/vsa_checker.sv
// Port-level checks for the video scope accumulator, bound to the top level.
module vsa_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input vsa_pkg::vsa_out_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  a_count_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.read_store == vsa_pkg::SEL_COUNT && result.read_index != 16'd0
    |-> result.count == 32'd0)
    else $error("pixel count read beyond bin zero returned data");

  a_unused_store: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.read_store > vsa_pkg::SEL_COUNT |-> result.count == 32'd0)
    else $error("unused store returned data");

  a_hist_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.read_store <= vsa_pkg::SEL_HIST_Y &&
    32'(result.read_index) >= 32'(vsa_pkg::HIST_BINS) |-> result.count == 32'd0)
    else $error("histogram read out of range returned data");

  a_narrow_bins: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.read_store >= vsa_pkg::SEL_WAVE &&
    result.read_store <= vsa_pkg::SEL_VECTOR |-> result.count[31:16] == 16'd0)
    else $error("16-bit scope bin exceeded its width");

endmodule

bind video_scope_accumulator vsa_checker u_vsa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
